// ----- design/fal_pkg.sv -----
`default_nettype none

package fal_pkg;

  // Field widths
  localparam int unsigned NUM_W = 16;
  localparam int unsigned DEN_W = 15;
  localparam int unsigned SUM_W = 32;
  localparam int unsigned LCM_W = 30;

  // Shared multiplier operand widths: signed numerator by zero-extended factor
  localparam int unsigned MUL_A_W = NUM_W + 1;
  localparam int unsigned MUL_B_W = DEN_W + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Remainder unit step counter
  localparam int unsigned DIV_CNT_W = $clog2(DEN_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GCD_GO,
    S_GCD_WAIT,
    S_FA_GO,
    S_FA_WAIT,
    S_FB_GO,
    S_FB_WAIT,
    S_MUL_L,
    S_MUL_A,
    S_MUL_B,
    S_DONE
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- design/fraction_adder_lcm.sv -----
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  num_a_i, den_a_i, num_b_i, den_b_i
// out      output     out_valid_o/out_stall_i sum_num_o, sum_den_o, den_error_o
//
// One item at a time. Each 15-bit remainder is a serial pass on the shared divider;
// the Euclid loop runs k remainder steps, k being 1 to 22. A zero denominator
// skips the divider and multiplier and goes straight to the done state.
// Reset clears the sequencer and the output valid; no clearing pass.
// in_stall_o is high while an item is in progress; a stalled result is held in
// the output register and the next item may be taken meanwhile.
module fraction_adder_lcm (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [fal_pkg::NUM_W-1:0]  num_a_i,
  input  wire logic        [fal_pkg::DEN_W-1:0]  den_a_i,
  input  wire logic signed [fal_pkg::NUM_W-1:0]  num_b_i,
  input  wire logic        [fal_pkg::DEN_W-1:0]  den_b_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [fal_pkg::SUM_W-1:0]       sum_num_o,
  output logic        [fal_pkg::LCM_W-1:0]       sum_den_o,
  output logic                                   den_error_o
);

  fal_pkg::state_e state_q, state_d;

  logic signed [fal_pkg::NUM_W-1:0] na_q, nb_q;
  logic [fal_pkg::DEN_W-1:0]        da_q, db_q;
  logic [fal_pkg::DEN_W-1:0]        x_q, y_q;
  logic [fal_pkg::DEN_W-1:0]        fa_q, fb_q;
  logic                             err_q;
  logic signed [fal_pkg::SUM_W-1:0] prod_q, acc_q;
  logic [fal_pkg::LCM_W-1:0]        lcm_q;

  logic                             out_valid_q;
  logic signed [fal_pkg::SUM_W-1:0] out_num_q;
  logic [fal_pkg::LCM_W-1:0]        out_den_q;
  logic                             out_err_q;

  logic                             in_xfer;
  logic                             den_zero;
  logic                             out_free;
  logic                             out_load;

  fal_pkg::div_ctrl_t               div_ctrl;
  fal_pkg::div_stat_t               div_stat;
  logic [fal_pkg::DEN_W-1:0]        div_dvd, div_dsr;
  logic [fal_pkg::DEN_W-1:0]        div_quot, div_rem;

  logic signed [fal_pkg::MUL_A_W-1:0] mul_a;
  logic signed [fal_pkg::MUL_B_W-1:0] mul_b;
  logic signed [fal_pkg::MUL_P_W-1:0] mul_p;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign den_zero = (den_a_i == '0) || (den_b_i == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fal_pkg::S_IDLE: begin
        if (in_valid_i) state_d = den_zero ? fal_pkg::S_DONE : fal_pkg::S_GCD_GO;
      end
      fal_pkg::S_GCD_GO:   state_d = fal_pkg::S_GCD_WAIT;
      fal_pkg::S_GCD_WAIT: begin
        if (div_stat.done) state_d = (div_rem == '0) ? fal_pkg::S_FA_GO : fal_pkg::S_GCD_GO;
      end
      fal_pkg::S_FA_GO:    state_d = fal_pkg::S_FA_WAIT;
      fal_pkg::S_FA_WAIT: begin
        if (div_stat.done) state_d = fal_pkg::S_FB_GO;
      end
      fal_pkg::S_FB_GO:    state_d = fal_pkg::S_FB_WAIT;
      fal_pkg::S_FB_WAIT: begin
        if (div_stat.done) state_d = fal_pkg::S_MUL_L;
      end
      fal_pkg::S_MUL_L:    state_d = fal_pkg::S_MUL_A;
      fal_pkg::S_MUL_A:    state_d = fal_pkg::S_MUL_B;
      fal_pkg::S_MUL_B:    state_d = fal_pkg::S_DONE;
      fal_pkg::S_DONE: begin
        if (out_free) state_d = fal_pkg::S_IDLE;
      end
      default:             state_d = fal_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider start and operand select
  always_comb begin
    in_stall_o     = 1'b1;
    div_ctrl.start = 1'b0;
    div_dvd        = x_q;
    div_dsr        = y_q;
    out_load       = 1'b0;
    unique case (state_q)
      fal_pkg::S_IDLE:   in_stall_o = 1'b0;
      fal_pkg::S_GCD_GO: div_ctrl.start = 1'b1;
      fal_pkg::S_FA_GO: begin
        div_ctrl.start = 1'b1;
        div_dvd        = db_q;
        div_dsr        = x_q;
      end
      fal_pkg::S_FB_GO: begin
        div_ctrl.start = 1'b1;
        div_dvd        = da_q;
        div_dsr        = x_q;
      end
      fal_pkg::S_DONE:   out_load = out_free;
      default: ;
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      fal_pkg::S_MUL_A: begin
        mul_a = fal_pkg::MUL_A_W'(na_q);
        mul_b = $signed({1'b0, fa_q});
      end
      fal_pkg::S_MUL_B: begin
        mul_a = fal_pkg::MUL_A_W'(nb_q);
        mul_b = $signed({1'b0, fb_q});
      end
      default: begin
        mul_a = $signed({2'b00, da_q});
        mul_b = $signed({1'b0, fa_q});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  fal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fal_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      na_q  <= num_a_i;
      nb_q  <= num_b_i;
      da_q  <= den_a_i;
      db_q  <= den_b_i;
      x_q   <= den_a_i;
      y_q   <= den_b_i;
      err_q <= den_zero;
    end
    // Advance Euclid: x takes y, y takes the remainder
    if (state_q == fal_pkg::S_GCD_WAIT && div_stat.done) begin
      x_q <= y_q;
      y_q <= div_rem;
    end
    if (state_q == fal_pkg::S_FA_WAIT && div_stat.done) fa_q <= div_quot;
    if (state_q == fal_pkg::S_FB_WAIT && div_stat.done) fb_q <= div_quot;
    if (state_q == fal_pkg::S_MUL_L || state_q == fal_pkg::S_MUL_A ||
        state_q == fal_pkg::S_MUL_B) begin
      prod_q <= mul_p[fal_pkg::SUM_W-1:0];
    end
    if (state_q == fal_pkg::S_MUL_A) lcm_q <= prod_q[fal_pkg::LCM_W-1:0];
    if (state_q == fal_pkg::S_MUL_B) acc_q <= prod_q;
    // Load the result register; drop to zero on a denominator error
    if (out_load) begin
      out_num_q <= err_q ? '0 : acc_q + prod_q;
      out_den_q <= err_q ? '0 : lcm_q;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_num_o   = out_num_q;
  assign sum_den_o   = out_den_q;
  assign den_error_o = out_err_q;

  // Divider is only started when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A good item goes straight into the Euclid loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !den_zero) |=> state_q == fal_pkg::S_GCD_GO)
    else $error("accepted item did not start the gcd loop");

  // Error results carry zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && den_error_o) |-> (sum_num_o == '0 && sum_den_o == '0))
    else $error("error result with nonzero fields");

  // Valid results have a nonzero common denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !den_error_o) |-> sum_den_o != '0)
    else $error("zero lcm on valid result");

endmodule

`default_nettype wire

// ----- design/fal_div.sv -----
`default_nettype none

// Bit-serial restoring divider: one quotient bit per cycle.
module fal_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fal_pkg::div_ctrl_t           ctrl_i,
  input  wire logic [fal_pkg::DEN_W-1:0]    dividend_i,
  input  wire logic [fal_pkg::DEN_W-1:0]    divisor_i,
  output fal_pkg::div_stat_t                stat_o,
  output logic [fal_pkg::DEN_W-1:0]         quot_o,
  output logic [fal_pkg::DEN_W-1:0]         rem_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [fal_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [fal_pkg::DEN_W-1:0]     rem_q, rem_d;
  logic [fal_pkg::DEN_W-1:0]     quo_q, quo_d;
  logic [fal_pkg::DEN_W-1:0]     dsr_q, dsr_d;
  logic [fal_pkg::DEN_W:0]       trial;
  logic [fal_pkg::DEN_W:0]       diff;
  logic                          ge;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    trial = {rem_q, quo_q[fal_pkg::DEN_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[fal_pkg::DEN_W-1:0] : trial[fal_pkg::DEN_W-1:0];
      quo_d = {quo_q[fal_pkg::DEN_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == fal_pkg::DIV_CNT_W'(fal_pkg::DEN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire
